// ----- src/jbt_pkg.sv -----
// Package for the packet jitter buffer tracker: field widths, status and kind
// codes, and parameter defaults. No dependencies.
package jbt_pkg;

    localparam int SLOTS_DEF = 64;

    localparam int WORD_W = 64;
    localparam int PLEN_W = 16;
    localparam int BUF_W  = 21;
    localparam int CNT_W  = 7;
    localparam int SLOT_W = 6;

    localparam logic [BUF_W-1:0] BUF_RESET = 21'd65536;

    localparam logic [1:0] KIND_PACKET = 2'd0;
    localparam logic [1:0] KIND_PLAY   = 2'd1;
    localparam logic [1:0] KIND_SCAN   = 2'd2;

    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_STALE    = 3'd1;
    localparam logic [2:0] ST_OLD      = 3'd2;
    localparam logic [2:0] ST_PLAY     = 3'd3;
    localparam logic [2:0] ST_SILENCE  = 3'd4;
    localparam logic [2:0] ST_NOTREADY = 3'd5;
    localparam logic [2:0] ST_MISSING  = 3'd6;
    localparam logic [2:0] ST_NONE     = 3'd7;

endpackage

// ----- src/jbt_in_if.sv -----
// Input channel of the jitter buffer tracker: valid/ready and request payload.
// Depends on jbt_pkg.
interface jbt_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    kind;
    logic [jbt_pkg::WORD_W-1:0]    sess_num;
    logic [jbt_pkg::WORD_W-1:0]    byte_offset;
    logic [jbt_pkg::PLEN_W-1:0]    payload_len;

    modport source (output valid, kind, sess_num, byte_offset, payload_len, input ready);
    modport sink   (input valid, kind, sess_num, byte_offset, payload_len, output ready);
endinterface

// ----- src/jbt_out_if.sv -----
// Result channel of the jitter buffer tracker: valid/ready and result payload.
// Depends on jbt_pkg.
interface jbt_out_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    status;
    logic [jbt_pkg::SLOT_W-1:0]    slot;
    logic [jbt_pkg::WORD_W-1:0]    offset_out;
    logic                          start_playout;
    logic                          last;

    modport source (output valid, status, slot, offset_out, start_playout, last, input ready);
    modport sink   (input valid, status, slot, offset_out, start_playout, last, output ready);
endinterface

// ----- src/packet_jitter_buffer_tracker_top.sv -----
// Packet jitter buffer tracker: slot ring, playout and missing-packet scan.
// Depends on jbt_pkg, jbt_in_if, jbt_out_if.
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+-------------------------------------------
//  in_ch     | in  | valid/ready      | kind, sess_num, byte_offset, payload_len
//  out_ch    | out | valid/ready      | status, slot, offset_out, start_playout, last
//  cfg       | in  | cfg_we           | cfg_wdata (buffer_bytes)
//
// One item at a time: a new request is taken only in idle, once the last result of
// the item before has gone into the output register. A packet that opens a session first
// counts slots by repeated add; packets, playouts and scans then run the 64-step bit walk
// (quotient, remainder, offset product); a scan then reads and checks entry by entry.
// A stale packet, not-ready playout or early empty scan goes straight to its result.
// Valid bits clear at once on a new session, so reset needs no clearing pass.
// Output stalls hold the sequencer.
module packet_jitter_buffer_tracker_top #(
    parameter int SLOTS = jbt_pkg::SLOTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [jbt_pkg::BUF_W-1:0]   cfg_wdata,
    jbt_in_if.sink                      in_ch,
    jbt_out_if.source                   out_ch
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [jbt_pkg::CNT_W-1:0] SLOTS_C = jbt_pkg::CNT_W'(SLOTS);
    localparam int W = jbt_pkg::WORD_W;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_CNT      = 9'b000000010,
        S_WALK     = 9'b000000100,
        S_PKT      = 9'b000001000,
        S_PLAY_RD  = 9'b000010000,
        S_PLAY_DO  = 9'b000100000,
        S_SCAN_RD  = 9'b001000000,
        S_SCAN_CHK = 9'b010000000,
        S_EMIT     = 9'b100000000
    } state_t;

    state_t state_reg;

    // configuration and session state
    logic [jbt_pkg::BUF_W-1:0]  bb_reg;
    logic                       have_reg;
    logic [W-1:0]               cur_reg;
    logic [W-1:0]               first_reg;
    logic [jbt_pkg::PLEN_W-1:0] psize_reg;
    logic [jbt_pkg::CNT_W-1:0]  sc_reg;
    logic [W-1:0]               hi_reg;
    logic [W-1:0]               thr_reg;
    logic                       playing_reg;
    logic [W-1:0]               pn_reg;
    logic [SLOTS-1:0]           vld_reg;

    // item and work registers
    logic [1:0]                 kind_reg;
    logic [W-1:0]               off_reg;
    logic [jbt_pkg::BUF_W:0]    acc_cnt_reg;
    logic [W-1:0]               val_reg;
    logic [W-1:0]               q_reg;
    logic [jbt_pkg::PLEN_W-1:0] rem_reg;
    logic [jbt_pkg::CNT_W-1:0]  md_reg;
    logic [W-1:0]               mul_reg;
    logic [5:0]                 bit_reg;
    logic [W-1:0]               i_reg;
    logic [jbt_pkg::CNT_W-1:0]  k_reg;

    // pending missing entry and result to send
    logic                       pend_v_reg;
    logic [jbt_pkg::SLOT_W-1:0] pend_slot_reg;
    logic [W-1:0]               pend_off_reg;
    logic [2:0]                 res_st_reg;
    logic [jbt_pkg::SLOT_W-1:0] res_slot_reg;
    logic [W-1:0]               res_off_reg;
    logic                       res_start_reg;
    logic                       res_last_reg;

    // output register
    logic                       ov_reg;
    logic [2:0]                 o_st_reg;
    logic [jbt_pkg::SLOT_W-1:0] o_slot_reg;
    logic [W-1:0]               o_off_reg;
    logic                       o_start_reg;
    logic                       o_last_reg;

    // slot memory
    logic [W-1:0]               slot_mem [SLOTS];
    logic [W-1:0]               rd_reg;
    logic                       rdv_reg;
    logic                       mem_we;
    logic [IDX_W-1:0]           addr;

    logic                       ofree;
    logic                       accept;
    logic                       new_sess;
    logic [W-1:0]               sc_w;
    logic [jbt_pkg::BUF_W+1:0]  bb3;
    logic [jbt_pkg::PLEN_W:0]   dv_t;
    logic                       qb;
    logic                       wb;
    logic [jbt_pkg::CNT_W:0]    md_t;
    logic [jbt_pkg::CNT_W-1:0]  md_next;
    logic [W-1:0]               seq;
    logic [jbt_pkg::CNT_W-1:0]  idx_inc;
    logic [jbt_pkg::BUF_W:0]    cnt_sum;

    assign ofree     = !ov_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept    = in_ch.valid && in_ch.ready;
    assign new_sess  = !have_reg || (in_ch.sess_num > cur_reg);
    assign sc_w      = {{(W-jbt_pkg::CNT_W){1'b0}}, sc_reg};
    assign bb3       = ({2'b00, bb_reg} << 1) + {2'b00, bb_reg};
    assign addr      = md_reg[IDX_W-1:0];
    assign seq       = rdv_reg ? rd_reg : '0;
    assign mem_we    = (state_reg == S_PKT) && (sc_reg != '0) &&
                       !((hi_reg >= sc_w) && (q_reg <= hi_reg - sc_w));
    assign idx_inc   = (md_reg + 7'd1 == sc_reg) ? '0 : md_reg + 7'd1;
    assign cnt_sum   = acc_cnt_reg + {{(jbt_pkg::BUF_W+1-jbt_pkg::PLEN_W){1'b0}}, psize_reg};

    // one restoring-division step, then reduce by slot count
    always_comb
    begin
        dv_t    = {rem_reg, val_reg[W-1]};
        qb      = dv_t >= {1'b0, psize_reg};
        wb      = (kind_reg == jbt_pkg::KIND_PACKET) ? qb : val_reg[W-1];
        md_t    = {md_reg, wb};
        md_next = (md_t >= {1'b0, sc_reg}) ? jbt_pkg::CNT_W'(md_t - {1'b0, sc_reg})
                                           : md_t[jbt_pkg::CNT_W-1:0];
    end

    // slot memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[addr] <= q_reg;
        end
        rd_reg <= slot_mem[addr];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            bb_reg      <= jbt_pkg::BUF_RESET;
            have_reg    <= 1'b0;
            cur_reg     <= '0;
            first_reg   <= '0;
            psize_reg   <= '0;
            sc_reg      <= '0;
            hi_reg      <= '0;
            thr_reg     <= '0;
            playing_reg <= 1'b0;
            pn_reg      <= '0;
            vld_reg     <= '0;
            rdv_reg     <= 1'b0;
            ov_reg      <= 1'b0;
            pend_v_reg  <= 1'b0;
            k_reg       <= '0;
        end
        else
        begin
            rdv_reg <= vld_reg[addr];
            if (cfg_we)
            begin
                bb_reg <= cfg_wdata;
            end

            // drain output register unless a new result refills it
            if (ov_reg && out_ch.ready && (state_reg != S_EMIT))
            begin
                ov_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg  <= in_ch.kind;
                        off_reg   <= in_ch.byte_offset;
                        rem_reg   <= '0;
                        md_reg    <= '0;
                        mul_reg   <= '0;
                        bit_reg   <= '1;
                        res_start_reg <= 1'b0;
                        res_slot_reg  <= '0;
                        res_off_reg   <= '0;
                        res_last_reg  <= 1'b1;
                        case (in_ch.kind)
                            jbt_pkg::KIND_PACKET:
                            begin
                                if (new_sess)
                                begin
                                    have_reg    <= 1'b1;
                                    cur_reg     <= in_ch.sess_num;
                                    first_reg   <= in_ch.byte_offset;
                                    psize_reg   <= in_ch.payload_len;
                                    thr_reg     <= in_ch.byte_offset
                                                   + W'(bb3 >> 2)
                                                   - W'(in_ch.payload_len) + 64'd1;
                                    hi_reg      <= '0;
                                    playing_reg <= 1'b0;
                                    pn_reg      <= '0;
                                    vld_reg     <= '0;
                                    val_reg     <= '0;
                                    acc_cnt_reg <= '0;
                                    sc_reg      <= '0;
                                    state_reg   <= S_CNT;
                                end
                                else if (in_ch.sess_num < cur_reg)
                                begin
                                    res_st_reg <= jbt_pkg::ST_STALE;
                                    state_reg  <= S_EMIT;
                                end
                                else
                                begin
                                    val_reg   <= in_ch.byte_offset - first_reg;
                                    state_reg <= S_WALK;
                                end
                            end
                            jbt_pkg::KIND_PLAY:
                            begin
                                if (!have_reg || !playing_reg || sc_reg == '0 ||
                                    pn_reg > hi_reg)
                                begin
                                    res_st_reg <= jbt_pkg::ST_NOTREADY;
                                    state_reg  <= S_EMIT;
                                end
                                else
                                begin
                                    val_reg   <= pn_reg;
                                    state_reg <= S_WALK;
                                end
                            end
                            jbt_pkg::KIND_SCAN:
                            begin
                                if (!have_reg || sc_reg == '0)
                                begin
                                    res_st_reg <= jbt_pkg::ST_NONE;
                                    state_reg  <= S_EMIT;
                                end
                                else
                                begin
                                    val_reg <= (hi_reg >= sc_w) ? hi_reg - sc_w + 64'd1 : '0;
                                    i_reg   <= (hi_reg >= sc_w) ? hi_reg - sc_w + 64'd1 : '0;
                                    k_reg      <= '0;
                                    pend_v_reg <= 1'b0;
                                    state_reg  <= S_WALK;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end

                // count slots by repeated add, saturate at SLOTS
                S_CNT:
                begin
                    if (psize_reg == '0)
                    begin
                        sc_reg    <= SLOTS_C;
                        state_reg <= S_WALK;
                    end
                    else if (sc_reg == SLOTS_C || cnt_sum > {1'b0, bb_reg})
                    begin
                        state_reg <= S_WALK;
                    end
                    else
                    begin
                        sc_reg      <= sc_reg + 7'd1;
                        acc_cnt_reg <= cnt_sum;
                    end
                end

                // one bit per cycle, MSB first
                S_WALK:
                begin
                    val_reg <= {val_reg[W-2:0], 1'b0};
                    rem_reg <= qb ? jbt_pkg::PLEN_W'(dv_t - {1'b0, psize_reg})
                                  : dv_t[jbt_pkg::PLEN_W-1:0];
                    q_reg   <= {q_reg[W-2:0], qb};
                    md_reg  <= md_next;
                    mul_reg <= {mul_reg[W-2:0], 1'b0}
                               + (wb ? W'(psize_reg) : '0);
                    bit_reg <= bit_reg - 6'd1;
                    if (bit_reg == '0)
                    begin
                        case (kind_reg)
                            jbt_pkg::KIND_PACKET: state_reg <= S_PKT;
                            jbt_pkg::KIND_PLAY:   state_reg <= S_PLAY_RD;
                            default:              state_reg <= S_SCAN_RD;
                        endcase
                    end
                end

                // window check, record slot
                S_PKT:
                begin
                    if (mem_we)
                    begin
                        vld_reg[addr] <= 1'b1;
                        if (q_reg > hi_reg)
                        begin
                            hi_reg <= q_reg;
                        end
                        if (!playing_reg && off_reg >= thr_reg)
                        begin
                            playing_reg   <= 1'b1;
                            res_start_reg <= 1'b1;
                        end
                        res_st_reg   <= jbt_pkg::ST_STORED;
                        res_slot_reg <= md_reg[jbt_pkg::SLOT_W-1:0];
                    end
                    else
                    begin
                        res_st_reg <= jbt_pkg::ST_OLD;
                    end
                    state_reg <= S_EMIT;
                end

                S_PLAY_RD:
                begin
                    state_reg <= S_PLAY_DO;
                end

                S_PLAY_DO:
                begin
                    res_slot_reg <= md_reg[jbt_pkg::SLOT_W-1:0];
                    if (pn_reg > seq)
                    begin
                        pn_reg     <= pn_reg + 64'd1;
                        res_st_reg <= jbt_pkg::ST_SILENCE;
                    end
                    else
                    begin
                        pn_reg     <= seq + 64'd1;
                        res_st_reg <= jbt_pkg::ST_PLAY;
                    end
                    state_reg <= S_EMIT;
                end

                // end of scan or issue read for entry i
                S_SCAN_RD:
                begin
                    if (i_reg >= hi_reg || k_reg == SLOTS_C - 7'd1)
                    begin
                        res_last_reg <= 1'b1;
                        if (pend_v_reg)
                        begin
                            res_st_reg   <= jbt_pkg::ST_MISSING;
                            res_slot_reg <= pend_slot_reg;
                            res_off_reg  <= pend_off_reg;
                        end
                        else
                        begin
                            res_st_reg   <= jbt_pkg::ST_NONE;
                            res_slot_reg <= '0;
                            res_off_reg  <= '0;
                        end
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_SCAN_CHK;
                    end
                end

                // compare entry, hold one missing entry back to mark the last
                S_SCAN_CHK:
                begin
                    if (seq != i_reg)
                    begin
                        k_reg         <= k_reg + 7'd1;
                        pend_v_reg    <= 1'b1;
                        pend_slot_reg <= md_reg[jbt_pkg::SLOT_W-1:0];
                        pend_off_reg  <= mul_reg + first_reg;
                        if (pend_v_reg)
                        begin
                            res_st_reg   <= jbt_pkg::ST_MISSING;
                            res_slot_reg <= pend_slot_reg;
                            res_off_reg  <= pend_off_reg;
                            res_last_reg <= 1'b0;
                            state_reg    <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_SCAN_RD;
                        end
                    end
                    else
                    begin
                        state_reg <= S_SCAN_RD;
                    end
                    i_reg   <= i_reg + 64'd1;
                    md_reg  <= idx_inc;
                    mul_reg <= mul_reg + W'(psize_reg);
                end

                // transfer result into the output register
                S_EMIT:
                begin
                    if (ofree)
                    begin
                        ov_reg      <= 1'b1;
                        o_st_reg    <= res_st_reg;
                        o_slot_reg  <= res_slot_reg;
                        o_off_reg   <= res_off_reg;
                        o_start_reg <= res_start_reg;
                        o_last_reg  <= res_last_reg;
                        state_reg   <= res_last_reg ? S_IDLE : S_SCAN_RD;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid         = ov_reg;
    assign out_ch.status        = o_st_reg;
    assign out_ch.slot          = o_slot_reg;
    assign out_ch.offset_out    = o_off_reg;
    assign out_ch.start_playout = o_start_reg;
    assign out_ch.last          = o_last_reg;

endmodule

// ----- bench/jbt_checker.sv -----
// Result checker for the packet jitter buffer tracker: tracks the ring state,
// predicts results per accepted request and compares them with the output.
// Depends on jbt_pkg, jbt_in_if, jbt_out_if.
module jbt_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [jbt_pkg::BUF_W-1:0] cfg_wdata,
    jbt_in_if                         in_ch,
    jbt_out_if                        out_ch,
    output int                        fails,
    output int                        pending
);

    typedef struct {
        logic [2:0]                 status;
        logic [jbt_pkg::SLOT_W-1:0] slot;
        logic [63:0]                offset_out;
        logic                       start_playout;
        logic                       last;
    } ring_result_t;

    ring_result_t due_results[$];

    logic [63:0] buf_bytes;
    logic        in_session;
    logic [63:0] cur_session;
    logic [63:0] base_offset;
    logic [63:0] pay_size;
    logic [63:0] ring_len;
    logic [63:0] top_seq;
    logic [63:0] start_mark;
    logic        is_playing;
    logic [63:0] next_play;
    logic [63:0] seq_tbl[jbt_pkg::SLOTS_DEF];

    assign pending = due_results.size();

    function automatic logic [63:0] qdiv(logic [63:0] a, logic [63:0] b);
        return (b == 0) ? '1 : a / b;
    endfunction

    task automatic push_result(logic [2:0] st, logic [63:0] sl, logic [63:0] off,
                               logic strt, logic lst);
        ring_result_t r;
        r.status        = st;
        r.slot          = sl[jbt_pkg::SLOT_W-1:0];
        r.offset_out    = off;
        r.start_playout = strt;
        r.last          = lst;
        due_results.push_back(r);
    endtask

    // Advance the ring state for one packet
    task automatic track_packet(logic [63:0] sess, logic [63:0] off, logic [63:0] plen);
        logic [63:0] q;
        logic [63:0] n;
        logic [63:0] idx;
        logic        strt;
        strt = 1'b0;
        if (!in_session || sess > cur_session)
        begin
            in_session  = 1'b1;
            cur_session = sess;
            base_offset = off;
            pay_size    = plen;
            q           = qdiv(buf_bytes, plen);
            ring_len    = (q > jbt_pkg::SLOTS_DEF) ? 64'(jbt_pkg::SLOTS_DEF) : q;
            start_mark  = off + (buf_bytes * 3) / 4 - plen + 1;
            top_seq     = 0;
            is_playing  = 1'b0;
            next_play   = 0;
            foreach (seq_tbl[i]) seq_tbl[i] = 0;
        end
        if (sess < cur_session)
        begin
            push_result(jbt_pkg::ST_STALE, 0, 0, 0, 1);
            return;
        end
        n = qdiv(off - base_offset, pay_size);
        if (ring_len == 0 || (top_seq >= ring_len && n <= top_seq - ring_len))
        begin
            push_result(jbt_pkg::ST_OLD, 0, 0, 0, 1);
            return;
        end
        idx = n % ring_len;
        seq_tbl[idx] = n;
        if (n > top_seq) top_seq = n;
        if (!is_playing && off >= start_mark)
        begin
            is_playing = 1'b1;
            strt       = 1'b1;
        end
        push_result(jbt_pkg::ST_STORED, idx, 0, strt, 1);
    endtask

    // Pick the next slot to play, or silence
    task automatic track_play();
        logic [63:0] idx;
        logic [63:0] seq;
        if (!in_session || !is_playing || ring_len == 0 || next_play > top_seq)
        begin
            push_result(jbt_pkg::ST_NOTREADY, 0, 0, 0, 1);
            return;
        end
        idx = next_play % ring_len;
        seq = seq_tbl[idx];
        if (next_play > seq)
        begin
            next_play = next_play + 1;
            push_result(jbt_pkg::ST_SILENCE, idx, 0, 0, 1);
        end
        else
        begin
            next_play = seq + 1;
            push_result(jbt_pkg::ST_PLAY, idx, 0, 0, 1);
        end
    endtask

    // List the holes inside the window
    task automatic track_scan();
        logic [63:0] i;
        logic [63:0] idx;
        int          k;
        i = 0;
        k = 0;
        if (!in_session || ring_len == 0)
        begin
            push_result(jbt_pkg::ST_NONE, 0, 0, 0, 1);
            return;
        end
        if (top_seq >= ring_len) i = top_seq - ring_len + 1;
        while (i < top_seq && k < jbt_pkg::SLOTS_DEF - 1)
        begin
            idx = i % ring_len;
            if (seq_tbl[idx] != i)
            begin
                push_result(jbt_pkg::ST_MISSING, idx, i * pay_size + base_offset, 0, 0);
                k++;
            end
            i++;
        end
        if (k == 0)
            push_result(jbt_pkg::ST_NONE, 0, 0, 0, 1);
        else
            due_results[$].last = 1'b1;
    endtask

    // Track configuration writes and accepted requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_bytes   = 64'(jbt_pkg::BUF_RESET);
            in_session  = 1'b0;
            cur_session = 0;
            base_offset = 0;
            pay_size    = 0;
            ring_len    = 0;
            top_seq     = 0;
            start_mark  = 0;
            is_playing  = 1'b0;
            next_play   = 0;
            foreach (seq_tbl[i]) seq_tbl[i] = 0;
        end
        else
        begin
            if (cfg_we) buf_bytes = 64'(cfg_wdata);
            if (in_ch.valid && in_ch.ready)
            begin
                case (in_ch.kind)
                    jbt_pkg::KIND_PACKET: track_packet(in_ch.sess_num, in_ch.byte_offset,
                                                       64'(in_ch.payload_len));
                    jbt_pkg::KIND_PLAY:   track_play();
                    jbt_pkg::KIND_SCAN:   track_scan();
                    default:              ;
                endcase
            end
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        ring_result_t e;
        if (!rst_n)
        begin
            fails <= 0;
        end
        else if (out_ch.valid && out_ch.ready)
        begin
            if (due_results.size() == 0)
            begin
                $error("unexpected result: status %0d", out_ch.status);
                fails <= fails + 1;
            end
            else
            begin
                e = due_results.pop_front();
                if (out_ch.status !== e.status ||
                    out_ch.slot !== e.slot ||
                    out_ch.offset_out !== e.offset_out ||
                    out_ch.start_playout !== e.start_playout ||
                    out_ch.last !== e.last)
                    fails <= fails + 1;
                if (out_ch.status !== e.status)
                    $error("status: expected %0d actual %0d", e.status, out_ch.status);
                if (out_ch.slot !== e.slot)
                    $error("slot: expected %0d actual %0d", e.slot, out_ch.slot);
                if (out_ch.offset_out !== e.offset_out)
                    $error("offset_out: expected %h actual %h", e.offset_out,
                           out_ch.offset_out);
                if (out_ch.start_playout !== e.start_playout)
                    $error("start_playout: expected %0d actual %0d", e.start_playout,
                           out_ch.start_playout);
                if (out_ch.last !== e.last)
                    $error("last: expected %0d actual %0d", e.last, out_ch.last);
            end
        end
    end

endmodule

// ----- bench/testbench.sv -----
// Top of the jitter buffer tracker bench: clock, reset, request stimulus,
// result back-pressure and verdict. Depends on jbt_pkg, both channel
// interfaces, jbt_checker and packet_jitter_buffer_tracker_top.
module testbench;

    localparam int SETTLE    = 260;
    localparam int MAX_CYCLE = 3000000;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [jbt_pkg::BUF_W-1:0] cfg_wdata;
    int                        fails;
    int                        pending;
    int                        cycle_cnt;
    int                        hold_cnt;
    logic                      calm;

    logic [63:0] sess_now;
    logic [63:0] base_off;
    logic [63:0] plen_now;
    logic [63:0] seq_next;
    logic [63:0] buf_now;

    jbt_in_if  in_ch();
    jbt_out_if out_ch();

    packet_jitter_buffer_tracker_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    jbt_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .fails     (fails),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drop result ready at random after each transfer, never while calm
    always @(posedge clk or negedge rst_n)
    begin
        int n;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_cnt     <= 0;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt     <= hold_cnt - 1;
            out_ch.ready <= (hold_cnt == 1);
        end
        else if (out_ch.valid && out_ch.ready)
        begin
            n            = calm ? 0 : $urandom_range(0, 3);
            hold_cnt     <= n;
            out_ch.ready <= (n == 0);
        end
        else
            out_ch.ready <= 1'b1;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLE)
        begin
            $display("packet_jitter_buffer_tracker_top test failed");
            $finish;
        end
    end

    // Hold one request until its transfer
    task automatic send(logic [1:0] kind, logic [63:0] sess, logic [63:0] off,
                        logic [15:0] plen);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= kind;
        in_ch.sess_num    <= sess;
        in_ch.byte_offset <= off;
        in_ch.payload_len <= plen;
        @(negedge clk);
        while (!in_ch.ready) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic send_pkt(logic [63:0] n);
        send(jbt_pkg::KIND_PACKET, sess_now, base_off + n * plen_now, plen_now[15:0]);
    endtask

    // Drop valid and wait until every result is in and the block is quiet
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_buf(logic [jbt_pkg::BUF_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        buf_now   = 64'(v);
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Open a session with a payload size that suits the current buffer
    task automatic open_session();
        logic [63:0] p;
        if (sess_now != '1) sess_now = sess_now + 1;
        base_off = {$urandom, $urandom};
        p = buf_now / 64'($urandom_range(8, 90));
        if (p == 0) p = 1;
        if (p > 65535) p = 65535;
        plen_now = p;
        seq_next = 0;
        send_pkt(0);
    endtask

    // Mostly in-order packets with holes, repeats and late ones, plus plays,
    // scans, stale and random requests
    task automatic run_stream(int count);
        int          done;
        int          r;
        logic [63:0] n;
        logic [63:0] rs;
        done = 0;
        open_session();
        while (done < count)
        begin
            r = $urandom_range(0, 99);
            done++;
            if (r < 50)
            begin
                n = seq_next;
                case ($urandom_range(0, 9))
                    0, 1: seq_next = seq_next + 64'($urandom_range(1, 3));
                    2:    n = (seq_next > 70) ? seq_next - 64'($urandom_range(1, 70)) : 0;
                    default: ;
                endcase
                send_pkt(n);
                if (n >= seq_next) seq_next = n + 1;
            end
            else if (r < 72)
                send(jbt_pkg::KIND_PLAY, {$urandom, $urandom}, {$urandom, $urandom},
                     16'($urandom));
            else if (r < 82)
                send(jbt_pkg::KIND_SCAN, {$urandom, $urandom}, {$urandom, $urandom},
                     16'($urandom));
            else if (r < 87)
                send(jbt_pkg::KIND_PACKET, (sess_now == 0) ? 64'd0 : sess_now - 1,
                     base_off, plen_now[15:0]);
            else if (r < 90)
            begin
                done--;
                send(2'd3, {$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom));
            end
            else if (r < 94)
                open_session();
            else
            begin
                rs = {$urandom, $urandom};
                if (rs > sess_now) sess_now = rs;
                send(jbt_pkg::KIND_PACKET, rs, {$urandom, $urandom}, 16'($urandom));
            end
        end
    endtask

    initial
    begin
        cycle_cnt         = 0;
        calm              = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        in_ch.valid       = 1'b0;
        in_ch.kind        = jbt_pkg::KIND_PACKET;
        in_ch.sess_num    = '0;
        in_ch.byte_offset = '0;
        in_ch.payload_len = '0;
        sess_now          = 0;
        base_off          = 0;
        plen_now          = 1;
        seq_next          = 0;
        buf_now           = 64'(jbt_pkg::BUF_RESET);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: no session, unused kind, zero payload, session zero
        send(jbt_pkg::KIND_PLAY, 0, 0, 0);
        send(jbt_pkg::KIND_SCAN, 0, 0, 0);
        send(2'd3, '1, '1, '1);
        send(jbt_pkg::KIND_PACKET, 0, 64'd100, 16'd0);
        send(jbt_pkg::KIND_PACKET, 0, 64'd5, 16'd0);
        send(jbt_pkg::KIND_PLAY, 0, 0, 0);
        send(jbt_pkg::KIND_SCAN, 0, 0, 0);
        // New session, holes, playout start, too old, stale
        sess_now = 5;
        base_off = 64'hFFFF_FFFF_FFFF_F000;
        plen_now = 1024;
        for (int i = 0; i < 50; i += 3) send_pkt(64'(i));
        send(jbt_pkg::KIND_SCAN, 0, 0, 0);
        send_pkt(100);
        send_pkt(10);
        send(jbt_pkg::KIND_PLAY, 0, 0, 0);
        send(jbt_pkg::KIND_PLAY, 0, 0, 0);
        send(jbt_pkg::KIND_PACKET, 4, 0, 16'd1);
        send(jbt_pkg::KIND_PACKET, 6, '1, 16'hFFFF);
        send(jbt_pkg::KIND_PLAY, 0, 0, 0);
        send(jbt_pkg::KIND_SCAN, 0, 0, 0);

        // Payload larger than the buffer: ring of zero length
        write_buf(21'd1);
        sess_now = 7;
        send(jbt_pkg::KIND_PACKET, sess_now, 64'd0, 16'd2);
        send(jbt_pkg::KIND_PACKET, sess_now, 64'd4, 16'd2);
        send(jbt_pkg::KIND_PLAY, 0, 0, 0);
        send(jbt_pkg::KIND_SCAN, 0, 0, 0);
        run_stream(15);

        write_buf(21'd1024);
        run_stream(55);

        // Let every result arrive before sending more
        drain();
        calm = 1'b1;
        run_stream(30);
        calm = 1'b0;

        write_buf(21'd1048576);
        run_stream(40);

        write_buf(21'h1FFFFF);
        run_stream(35);

        write_buf(21'd3000);
        run_stream(40);
        sess_now = '1;
        send(jbt_pkg::KIND_PACKET, sess_now, 64'd0, 16'd40);
        send_pkt(3);
        send(jbt_pkg::KIND_PLAY, 0, 0, 0);
        send(jbt_pkg::KIND_SCAN, 0, 0, 0);

        drain();
        if (fails == 0)
            $display("packet_jitter_buffer_tracker_top test passed");
        else
            $display("packet_jitter_buffer_tracker_top test failed");
        $finish;
    end

endmodule
